// ===== rtl/sfcb_pkg.sv =====
// ----------------------------------------------------------------------------
// sfcb_pkg
// Types and constants shared by the serial frame to CAN bridge.
// ----------------------------------------------------------------------------
package sfcb_pkg;

  localparam logic [7:0]  HDR_BYTE       = 8'hA5;
  localparam int          BODY_LEN       = 22;
  // Bytes held in the chain; the final body byte goes straight to the buffer.
  localparam int          CELL_CNT       = BODY_LEN - 1;
  localparam logic [4:0]  LAST_BODY_IDX  = 5'(BODY_LEN - 1);
  localparam logic [7:0]  IDLE_LIMIT_RST = 8'd15;
  localparam logic [10:0] BASE_ID_RST    = 11'h701;

  localparam logic        CFG_IDX_IDLE_LIMIT = 1'b0;
  localparam logic        CFG_IDX_BASE_ID    = 1'b1;

  localparam logic        CMD_BYTE = 1'b0;
  localparam logic        CMD_TICK = 1'b1;

  localparam logic [1:0]  MSG_FIRST = 2'd0;
  localparam logic [1:0]  MSG_LAST  = 2'd2;
  localparam logic [3:0]  LEN_FULL  = 4'd8;
  localparam logic [3:0]  LEN_SHORT = 4'd7;

  typedef logic [7:0] byte_t;
  // Entry j holds frame byte j+1.
  typedef byte_t [BODY_LEN-1:0] body_t;

  typedef struct packed {
    logic  load;
    body_t body;
  } frame_load_t;

  typedef struct packed {
    logic full;
    logic last_pop;
  } drain_sts_t;

endpackage

// ===== rtl/sfcb_if.sv =====
// ----------------------------------------------------------------------------
// sfcb_in_if / sfcb_out_if
// Valid/ready channels for serial requests in and CAN messages out.
// ----------------------------------------------------------------------------
interface sfcb_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] rx_byte;

  modport source (output valid, cmd, rx_byte, input ready);
  modport sink   (input valid, cmd, rx_byte, output ready);
endinterface

interface sfcb_out_if;
  logic        valid;
  logic        ready;
  logic [10:0] can_id;
  logic [3:0]  data_len;
  logic [7:0]  data_b0;
  logic [7:0]  data_b1;
  logic [7:0]  data_b2;
  logic [7:0]  data_b3;
  logic [7:0]  data_b4;
  logic [7:0]  data_b5;
  logic [7:0]  data_b6;
  logic [7:0]  data_b7;
  logic        last_msg;

  modport source (output valid, can_id, data_len, data_b0, data_b1, data_b2, data_b3,
                  data_b4, data_b5, data_b6, data_b7, last_msg, input ready);
  modport sink   (input valid, can_id, data_len, data_b0, data_b1, data_b2, data_b3,
                  data_b4, data_b5, data_b6, data_b7, last_msg, output ready);
endinterface

// ===== rtl/sfcb_cell.sv =====
// ----------------------------------------------------------------------------
// sfcb_cell
// One byte stage of the frame chain; takes its neighbor's byte on a shift.
// ----------------------------------------------------------------------------
module sfcb_cell (
  input  logic       clk,
  input  logic       shift_en,
  input  logic [7:0] d_in,
  output logic [7:0] q_out
);

  logic [7:0] q_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      q_r <= d_in;
    end
  end

  assign q_out = q_r;

endmodule

// ===== rtl/sfcb_drain.sv =====
// ----------------------------------------------------------------------------
// sfcb_drain
// Frame buffer and message sequencer: sends a frame as three CAN messages.
// ----------------------------------------------------------------------------
module sfcb_drain (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [10:0]         base_id,
  input  sfcb_pkg::frame_load_t ld,
  output sfcb_pkg::drain_sts_t  sts,
  sfcb_out_if.source          out_chan
);
  import sfcb_pkg::*;

  logic       full_r, full_nxt;
  logic [1:0] msg_r, msg_nxt;
  body_t      body_r;
  logic       pop;
  byte_t      fb [0:23];
  byte_t      mb [0:7];

  assign pop = out_chan.valid & out_chan.ready;

  always_comb begin
    full_nxt = full_r;
    msg_nxt  = msg_r;
    if (ld.load) begin
      full_nxt = 1'b1;
      msg_nxt  = MSG_FIRST;
    end else if (pop) begin
      if (msg_r == MSG_LAST) begin
        full_nxt = 1'b0;
        msg_nxt  = MSG_FIRST;
      end else begin
        msg_nxt = msg_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
      msg_r  <= MSG_FIRST;
    end else begin
      full_r <= full_nxt;
      msg_r  <= msg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld.load) begin
      body_r <= ld.body;
    end
  end

  // Whole frame with header in front and the unused pad byte at the end.
  always_comb begin
    fb[0] = HDR_BYTE;
    for (int k = 1; k <= BODY_LEN; k++) begin
      fb[k] = body_r[k-1];
    end
    fb[23] = 8'h00;
    for (int i = 0; i < 8; i++) begin
      mb[i] = fb[{msg_r, 3'(i)}];
    end
  end

  assign out_chan.valid    = full_r;
  assign out_chan.can_id   = base_id + {9'd0, msg_r};
  assign out_chan.data_len = (msg_r == MSG_LAST) ? LEN_SHORT : LEN_FULL;
  assign out_chan.data_b0  = mb[0];
  assign out_chan.data_b1  = mb[1];
  assign out_chan.data_b2  = mb[2];
  assign out_chan.data_b3  = mb[3];
  assign out_chan.data_b4  = mb[4];
  assign out_chan.data_b5  = mb[5];
  assign out_chan.data_b6  = mb[6];
  assign out_chan.data_b7  = mb[7];
  assign out_chan.last_msg = (msg_r == MSG_LAST);

  assign sts.full     = full_r;
  assign sts.last_pop = pop & (msg_r == MSG_LAST);

endmodule

// ===== rtl/sensor_frame_to_can_bridge.sv =====
// ----------------------------------------------------------------------------
// sensor_frame_to_can_bridge
// Hunts for the 0xA5 header, gathers 22 body bytes through a byte chain with
// an idle-tick abort, and sends each frame as three CAN messages.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle. The only stall: once 21 body bytes are
//   gathered, the next request (byte or tick) waits while the frame buffer
//   still holds undelivered messages, until the cycle after the last leaves.
// Latency: first message is valid the cycle after the final byte; the three
//   messages then leave one per cycle, paced by out_chan.ready.
// Reset: clears hunt state, counters and buffer flag; registers take 15, 0x701.
// ----------------------------------------------------------------------------
module sensor_frame_to_can_bridge (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [10:0] cfg_wdata,
  sfcb_in_if.sink     in_chan,
  sfcb_out_if.source  out_chan
);
  import sfcb_pkg::*;

  logic [7:0]  idle_limit_r;
  logic [10:0] base_id_r;

  logic        collecting_r, collecting_nxt;
  logic [4:0]  gathered_r, gathered_nxt;
  logic [7:0]  idle_r, idle_nxt;
  logic [7:0]  idle_inc;
  logic        accept;
  logic        shift_en;
  logic        completing;
  byte_t       chain_q [CELL_CNT];
  frame_load_t ld;
  drain_sts_t  sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_limit_r <= IDLE_LIMIT_RST;
      base_id_r    <= BASE_ID_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_IDX_IDLE_LIMIT: idle_limit_r <= cfg_wdata[7:0];
        CFG_IDX_BASE_ID:    base_id_r    <= cfg_wdata;
        default:            ;
      endcase
    end
  end

  // Hold the next request (byte or tick) after 21 body bytes while the buffer is still draining.
  assign in_chan.ready = !(collecting_r && gathered_r == LAST_BODY_IDX && sts.full);
  assign accept        = in_chan.valid & in_chan.ready;
  assign shift_en      = accept & collecting_r & (in_chan.cmd == CMD_BYTE);
  assign completing    = shift_en & (gathered_r == LAST_BODY_IDX);
  assign idle_inc      = (idle_r == 8'hFF) ? idle_r : idle_r + 8'd1;

  always_comb begin
    collecting_nxt = collecting_r;
    gathered_nxt   = gathered_r;
    idle_nxt       = idle_r;
    if (accept) begin
      if (!collecting_r) begin
        if (in_chan.cmd == CMD_BYTE && in_chan.rx_byte == HDR_BYTE) begin
          collecting_nxt = 1'b1;
          gathered_nxt   = 5'd0;
          idle_nxt       = 8'd0;
        end
      end else if (in_chan.cmd == CMD_TICK) begin
        // Drop the partial frame once the idle limit is reached.
        if (idle_inc >= idle_limit_r) begin
          collecting_nxt = 1'b0;
          gathered_nxt   = 5'd0;
          idle_nxt       = 8'd0;
        end else begin
          idle_nxt = idle_inc;
        end
      end else begin
        idle_nxt = 8'd0;
        if (completing) begin
          collecting_nxt = 1'b0;
          gathered_nxt   = 5'd0;
        end else begin
          gathered_nxt = gathered_r + 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      collecting_r <= 1'b0;
      gathered_r   <= 5'd0;
      idle_r       <= 8'd0;
    end else begin
      collecting_r <= collecting_nxt;
      gathered_r   <= gathered_nxt;
      idle_r       <= idle_nxt;
    end
  end

  // Byte chain: cell 0 takes the newest byte, older bytes move up.
  for (genvar c = 0; c < CELL_CNT; c++) begin : g_cell
    sfcb_cell u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .d_in     ((c == 0) ? in_chan.rx_byte : chain_q[(c == 0) ? 0 : c-1]),
      .q_out    (chain_q[c])
    );
  end

  always_comb begin
    ld.load = completing;
    for (int j = 0; j < CELL_CNT; j++) begin
      ld.body[j] = chain_q[CELL_CNT-1-j];
    end
    ld.body[BODY_LEN-1] = in_chan.rx_byte;
  end

  sfcb_drain u_drain (
    .clk      (clk),
    .rst_n    (rst_n),
    .base_id  (base_id_r),
    .ld       (ld),
    .sts      (sts),
    .out_chan (out_chan)
  );

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ld.load |-> !sts.full)
    else $error("frame loaded over undelivered messages");

  a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (sts.last_pop && !ld.load) |=> !out_chan.valid)
    else $error("buffer still valid after last message");

  a_drain_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.ready && !out_chan.last_msg) |=> out_chan.valid)
    else $error("frame dropped before its last message");

  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !collecting_r |-> (idle_r == 8'd0 && gathered_r == 5'd0))
    else $error("counters not clear while hunting");

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the serial frame to CAN bridge. A queue of serial
// requests (bytes and idle ticks) feeds a bursty driver. A bit-accurate model
// of the header hunt, body gathering and idle abort predicts the three CAN
// messages of each frame. A monitor behind a stalling receiver checks every
// message field by field. Register settings change between drained phases.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sfcb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_ITEMS  = 370;
  localparam int SETTLE      = 4;

  typedef struct packed {
    logic  cmd;
    byte_t rx_byte;
  } serial_req_t;

  typedef struct packed {
    logic [10:0]     can_id;
    logic [3:0]      data_len;
    byte_t [7:0]     data;
    logic            last_msg;
  } can_msg_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_idx;
  logic [10:0] cfg_wdata;

  sfcb_in_if  in_if ();
  sfcb_out_if out_if ();

  sensor_frame_to_can_bridge DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_if),
    .out_chan  (out_if)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Bridge model state and register copies
  logic        in_frame;
  logic [4:0]  body_cnt;
  logic [7:0]  idle_ticks;
  byte_t       body_bytes [BODY_LEN];
  logic [7:0]  idle_limit_q;
  logic [10:0] base_id_q;

  serial_req_t serial_q [$];
  can_msg_t    pending_msgs [$];

  int queued_total   = 0;
  int accepted_total = 0;
  int live_items     = 0;
  int frames_done    = 0;
  int aborts_seen    = 0;
  int msgs_checked   = 0;
  int cfg_writes     = 0;
  int mismatches     = 0;
  int cycles         = 0;

  int burst_left = 1;
  int gap_left   = 0;
  int stall_mode = 0;
  int stall_cnt  = 0;

  task automatic report_mismatch(string field, logic [31:0] exp_v, logic [31:0] got_v);
    $display("MISMATCH msg %0d %s: expected 0x%0h got 0x%0h",
             msgs_checked, field, exp_v, got_v);
    mismatches++;
  endtask

  // Advance the model by one accepted request; queue the messages of a
  // completed frame.
  task automatic advance_bridge(logic cmd, byte_t b);
    can_msg_t msg;
    int m;
    int i;
    int k;
    if (in_frame || (cmd == CMD_BYTE && b == HDR_BYTE)) live_items++;
    if (!in_frame) begin
      if (cmd == CMD_BYTE && b == HDR_BYTE) begin
        in_frame   = 1'b1;
        body_cnt   = '0;
        idle_ticks = '0;
      end
    end else if (cmd == CMD_TICK) begin
      if (idle_ticks != 8'hFF) idle_ticks++;
      // A zero limit behaves like one since the count is already nonzero here
      if (idle_ticks >= idle_limit_q) begin
        in_frame   = 1'b0;
        body_cnt   = '0;
        idle_ticks = '0;
        aborts_seen++;
      end
    end else begin
      idle_ticks = '0;
      if (body_cnt < BODY_LEN) begin
        body_bytes[body_cnt] = b;
        body_cnt++;
      end
      if (body_cnt == BODY_LEN) begin
        for (m = 0; m < 3; m++) begin
          msg.can_id   = base_id_q + 11'(m);
          msg.data_len = (m == 2) ? LEN_SHORT : LEN_FULL;
          for (i = 0; i < 8; i++) begin
            k = m * 8 + i;
            if (i >= msg.data_len) msg.data[i] = '0;
            else if (k == 0)       msg.data[i] = HDR_BYTE;
            else                   msg.data[i] = body_bytes[k-1];
          end
          msg.last_msg = (m == 2);
          pending_msgs.push_back(msg);
        end
        in_frame = 1'b0;
        body_cnt = '0;
        frames_done++;
      end
    end
  endtask

  // Driver: bursts of requests with random gaps
  always @(posedge clk) begin : drv
    serial_req_t req;
    if (!rst_n) begin
      in_if.valid   <= 1'b0;
      in_if.cmd     <= CMD_BYTE;
      in_if.rx_byte <= '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        advance_bridge(in_if.cmd, in_if.rx_byte);
        accepted_total++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (serial_q.size() > 0) begin
          req = serial_q.pop_front();
          in_if.cmd     <= req.cmd;
          in_if.rx_byte <= req.rx_byte;
          in_if.valid   <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each message against the oldest prediction, then stall
  always @(posedge clk) begin : mon
    can_msg_t    exp_msg;
    byte_t [7:0] got_data;
    int          i;
    if (rst_n && out_if.valid && out_if.ready) begin
      got_data = {out_if.data_b7, out_if.data_b6, out_if.data_b5, out_if.data_b4,
                  out_if.data_b3, out_if.data_b2, out_if.data_b1, out_if.data_b0};
      if (pending_msgs.size() == 0) begin
        report_mismatch("unexpected message, can_id", 32'd0, 32'(out_if.can_id));
      end else begin
        exp_msg = pending_msgs.pop_front();
        if (out_if.can_id !== exp_msg.can_id)
          report_mismatch("can_id", 32'(exp_msg.can_id), 32'(out_if.can_id));
        if (out_if.data_len !== exp_msg.data_len)
          report_mismatch("data_len", 32'(exp_msg.data_len), 32'(out_if.data_len));
        for (i = 0; i < 8; i++) begin
          if (got_data[i] !== exp_msg.data[i])
            report_mismatch($sformatf("data_b%0d", i), 32'(exp_msg.data[i]),
                            32'(got_data[i]));
        end
        if (out_if.last_msg !== exp_msg.last_msg)
          report_mismatch("last_msg", 32'(exp_msg.last_msg), 32'(out_if.last_msg));
      end
      msgs_checked++;
    end
    if (stall_cnt == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_cnt  = $urandom_range(20, 80);
    end else begin
      stall_cnt--;
    end
    case (stall_mode)
      0: out_if.ready <= 1'b1;
      1: out_if.ready <= 1'($urandom_range(0, 1));
      2: out_if.ready <= ($urandom_range(0, 4) == 0);
      default: out_if.ready <= (stall_cnt % 3 != 0);
    endcase
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic push_req(logic cmd, byte_t b);
    serial_req_t req;
    req.cmd     = cmd;
    req.rx_byte = b;
    serial_q.push_back(req);
    queued_total++;
  endtask

  function automatic int eff_limit();
    return (idle_limit_q == 0) ? 1 : int'(idle_limit_q);
  endfunction

  task automatic push_ticks(int n);
    repeat (n) push_req(CMD_TICK, byte_t'($urandom));
  endtask

  // Header plus 22 random body bytes, with tick runs that stay under the limit
  task automatic queue_frame();
    int    j;
    int    lim;
    byte_t b;
    lim = eff_limit();
    push_req(CMD_BYTE, HDR_BYTE);
    for (j = 0; j < BODY_LEN; j++) begin
      if (lim > 1 && $urandom_range(0, 5) == 0) begin
        if ($urandom_range(0, 15) == 0) push_ticks(lim - 1);
        else push_ticks($urandom_range(1, (lim - 1 < 4) ? lim - 1 : 4));
      end
      b = byte_t'($urandom);
      case ($urandom_range(0, 15))
        0: b = HDR_BYTE;
        1: b = 8'h00;
        2: b = 8'hFF;
        default: ;
      endcase
      push_req(CMD_BYTE, b);
    end
  endtask

  // Header, part of a body, then enough ticks to drop it
  task automatic queue_broken();
    int n;
    push_req(CMD_BYTE, HDR_BYTE);
    n = $urandom_range(0, BODY_LEN - 1);
    repeat (n) push_req(CMD_BYTE, byte_t'($urandom));
    push_ticks(eff_limit());
  endtask

  task automatic queue_noise();
    byte_t b;
    repeat ($urandom_range(1, 4)) begin
      b = byte_t'($urandom);
      if (b == HDR_BYTE) b = b ^ 8'h01;
      if ($urandom_range(0, 1) == 0) push_req(CMD_BYTE, b);
      else push_req(CMD_TICK, b);
    end
  endtask

  task automatic wait_drained();
    while (!(accepted_total == queued_total && pending_msgs.size() == 0))
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [10:0] wdata);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= wdata;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_IDX_IDLE_LIMIT) idle_limit_q = wdata[7:0];
    else base_id_q = wdata;
    cfg_writes++;
  endtask

  initial begin : stim
    int          phase;
    logic [10:0] lim_w;
    logic [10:0] base_w;
    int          r;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = CFG_IDX_IDLE_LIMIT;
    cfg_wdata     = '0;
    in_frame      = 1'b0;
    body_cnt      = '0;
    idle_ticks    = '0;
    idle_limit_q  = IDLE_LIMIT_RST;
    base_id_q     = BASE_ID_RST;
    foreach (body_bytes[i]) body_bytes[i] = '0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: ignored tick and byte while hunting, a frame with a
    // header value and extremes in its body and a tick in the middle
    push_req(CMD_TICK, 8'hFF);
    push_req(CMD_BYTE, 8'h00);
    push_req(CMD_BYTE, HDR_BYTE);
    push_req(CMD_BYTE, 8'hFF);
    push_req(CMD_BYTE, HDR_BYTE);
    push_req(CMD_BYTE, 8'h00);
    for (r = 3; r < 10; r++) push_req(CMD_BYTE, byte_t'(r * 37));
    push_req(CMD_TICK, 8'h00);
    for (r = 10; r < BODY_LEN; r++) push_req(CMD_BYTE, byte_t'(r * 91));
    wait_drained();

    // Zero idle limit: the first tick drops the frame
    write_reg(CFG_IDX_IDLE_LIMIT, 11'h000);
    write_reg(CFG_IDX_BASE_ID, 11'd2046);
    push_req(CMD_BYTE, HDR_BYTE);
    push_req(CMD_BYTE, 8'h12);
    push_req(CMD_TICK, 8'h5A);
    push_req(CMD_TICK, 8'hA5);
    wait_drained();

    phase = 0;
    while (queued_total < RAND_ITEMS) begin
      case (phase)
        0: begin lim_w = 11'd1;              base_w = 11'd2047; end
        1: begin lim_w = {3'b111, 8'd3};     base_w = 11'd2045; end
        2: begin lim_w = 11'd0;              base_w = 11'd2046; end
        3: begin lim_w = 11'd255;            base_w = 11'd0;    end
        default: begin
          lim_w  = ($urandom_range(0, 3) == 0) ? 11'($urandom)
                                               : 11'($urandom_range(1, 20));
          base_w = 11'($urandom);
        end
      endcase
      write_reg(CFG_IDX_IDLE_LIMIT, lim_w);
      write_reg(CFG_IDX_BASE_ID, base_w);
      repeat ($urandom_range(3, 6)) begin
        if (queued_total < RAND_ITEMS) begin
          r = $urandom_range(0, 9);
          if (r <= 6)      queue_frame();
          else if (r == 7) queue_broken();
          else             queue_noise();
        end
      end
      wait_drained();
      phase++;
    end

    while (!(accepted_total == queued_total && pending_msgs.size() == 0))
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (pending_msgs.size() != 0)
      report_mismatch("messages never delivered", 32'd0, pending_msgs.size());

    $display("Sent %0d requests (%0d past the hunt) over %0d register writes.",
             accepted_total, live_items, cfg_writes);
    $display("Checked %0d CAN messages from %0d frames; %0d frames dropped on idle.",
             msgs_checked, frames_done, aborts_seen);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/sfcb_pkg.sv
rtl/sfcb_if.sv
rtl/sfcb_cell.sv
rtl/sfcb_drain.sv
rtl/sensor_frame_to_can_bridge.sv
dv/tb.sv
